@@ rtl/hash_set_insert_search_top_assert.svh @@
// Assertion macros shared by the hash set checker.
`ifndef HASH_SET_INSERT_SEARCH_TOP_ASSERT_SVH
`define HASH_SET_INSERT_SEARCH_TOP_ASSERT_SVH

// Implication in the same cycle, disabled during reset.
`define HSS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hash set assertion failed");

// Implication checked in the cycle after the antecedent, disabled during reset.
`define HSS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hash set assertion failed");

`endif

@@ rtl/hss_pkg.sv @@
// Shared constants, status codes and types of the hash set.
package hss_pkg;

   localparam int NUM_BUCKETS_DEF = 1024;
   localparam int WAYS_DEF        = 4;

   localparam int KEY_W    = 32;
   localparam int STATUS_W = 3;

   // operation codes
   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_SEARCH = 1'b1;

   // result codes
   localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
   localparam logic [STATUS_W-1:0] ST_PRESENT   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_ABSENT    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

   // operation handed from the controller to the table
   typedef struct packed {
      logic             commit;
      logic             func;
      logic [KEY_W-1:0] key;
   } hss_op_type;

endpackage

@@ rtl/hss_hash.sv @@
// Bucket index unit: signed key modulo the bucket count, three stages.
module hss_hash #(
   parameter int NUM_BUCKETS = hss_pkg::NUM_BUCKETS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [hss_pkg::KEY_W-1:0]        key,
   output logic                             done,
   output logic [$clog2(NUM_BUCKETS)-1:0]   bucket
);
   import hss_pkg::*;

   localparam int BW = $clog2(NUM_BUCKETS);
   localparam int RW = BW + 1;
   // floor(2^32 / M): quotient estimate is low by at most one
   localparam logic [KEY_W-1:0] RECIP   = KEY_W'((64'd1 << 32) / NUM_BUCKETS);
   localparam logic [KEY_W-1:0] MOD_K   = KEY_W'(NUM_BUCKETS);
   localparam logic [RW-1:0]    MOD_R   = RW'(NUM_BUCKETS);
   // 2^32 mod M: correction for a negative key
   localparam logic [RW-1:0]    WRAP_R  = RW'((64'd1 << 32) % NUM_BUCKETS);

   logic                    v1_ff, v2_ff, done_ff;
   logic [2*KEY_W-1:0]      prod_ff, prod_in;
   logic [KEY_W-1:0]        key1_ff, key2_ff;
   logic [KEY_W-1:0]        qm_ff, qm_in;
   logic [BW-1:0]           bucket_ff, bucket_in;
   logic [KEY_W-1:0]        diff;
   logic [RW-1:0]           r0, r1, r2;

   // stage 1: multiply by reciprocal
   assign prod_in = (2*KEY_W)'(key) * (2*KEY_W)'(RECIP);

   // stage 2: quotient estimate times modulus, low word is enough
   assign qm_in = prod_ff[2*KEY_W-1:KEY_W] * MOD_K;

   // stage 3: remainder correction and sign fold
   always_comb begin
      diff = key2_ff - qm_ff;
      r0   = diff[RW-1:0];
      r1   = (r0 >= MOD_R) ? (r0 - MOD_R) : r0;
      if (!key2_ff[KEY_W-1]) begin
         r2 = r1;
      end else if (r1 >= WRAP_R) begin
         r2 = r1 - WRAP_R;
      end else begin
         r2 = r1 + MOD_R - WRAP_R;
      end
      bucket_in = r2[BW-1:0];
   end

   // advance the stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         v1_ff   <= start;
         v2_ff   <= v1_ff;
         done_ff <= v2_ff;
      end
   end

   // hold payload per stage
   always_ff @(posedge clock) begin
      if (start) begin
         prod_ff <= prod_in;
         key1_ff <= key;
      end
      if (v1_ff) begin
         qm_ff   <= qm_in;
         key2_ff <= key1_ff;
      end
      if (v2_ff) begin
         bucket_ff <= bucket_in;
      end
   end

   assign done   = done_ff;
   assign bucket = bucket_ff;

endmodule

@@ rtl/hss_table.sv @@
// Bucket row and fill count memories with way compare and insert write-back.
module hss_table #(
   parameter int NUM_BUCKETS = hss_pkg::NUM_BUCKETS_DEF,
   parameter int WAYS        = hss_pkg::WAYS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [$clog2(NUM_BUCKETS)-1:0]   bucket,
   input  hss_pkg::hss_op_type              op,
   output logic                             init_done,
   output logic [hss_pkg::STATUS_W-1:0]     status
);
   import hss_pkg::*;

   localparam int BW   = $clog2(NUM_BUCKETS);
   localparam int FW   = $clog2(WAYS + 1);
   localparam int ROWW = WAYS * KEY_W;

   logic [ROWW-1:0] key_mem  [NUM_BUCKETS];
   logic [FW-1:0]   fill_mem [NUM_BUCKETS];

   logic [ROWW-1:0] row_rd_ff;
   logic [FW-1:0]   fill_rd_ff;
   logic            clr_busy_ff, clr_busy_in;
   logic [BW-1:0]   clr_idx_ff, clr_idx_in;

   logic            hit, full, wr_en;
   logic [ROWW-1:0] row_wr;

   // compare valid ways against the key, build the updated row
   always_comb begin
      hit    = 1'b0;
      row_wr = row_rd_ff;
      for (int w = 0; w < WAYS; w++) begin
         if ((FW'(w) < fill_rd_ff) && (row_rd_ff[w*KEY_W +: KEY_W] == op.key)) begin
            hit = 1'b1;
         end
         if (FW'(w) == fill_rd_ff) begin
            row_wr[w*KEY_W +: KEY_W] = op.key;
         end
      end
   end

   assign full  = (fill_rd_ff >= FW'(WAYS));
   assign wr_en = op.commit && (op.func == FUNC_INSERT) && !hit && !full;

   // result code
   always_comb begin
      if (op.func == FUNC_SEARCH) begin
         status = hit ? ST_PRESENT : ST_ABSENT;
      end else if (hit) begin
         status = ST_DUPLICATE;
      end else if (full) begin
         status = ST_FULL;
      end else begin
         status = ST_INSERTED;
      end
   end

   // sweep fill counts to zero after reset
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_idx_in  = clr_idx_ff;
      if (clr_busy_ff) begin
         clr_idx_in = clr_idx_ff + BW'(1);
         if (clr_idx_ff == BW'(NUM_BUCKETS - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_idx_ff  <= clr_idx_in;
      end
   end

   // fill count memory: one write port, registered read
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         fill_mem[clr_idx_ff] <= '0;
      end else if (wr_en) begin
         fill_mem[bucket] <= fill_rd_ff + FW'(1);
      end
      fill_rd_ff <= fill_mem[bucket];
   end

   // key row memory: one write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[bucket] <= row_wr;
      end
      row_rd_ff <= key_mem[bucket];
   end

   assign init_done = !clr_busy_ff;

endmodule

@@ rtl/hash_set_insert_search_top.sv @@
// The request is registered, hashed, then compared and written back; one request in flight.
// A new request is accepted only after the previous one commits, once it has passed the 3-stage
// bucket modulo unit, the registered bucket row read and the compare/write-back.
// Reset: synchronous, active high; afterwards the fill counts are swept to zero,
// and req_ready stays low until the sweep is done.
// Key slots are not cleared; only ways below a bucket's fill count are compared.
module hash_set_insert_search_top #(
   parameter int NUM_BUCKETS = hss_pkg::NUM_BUCKETS_DEF,
   parameter int WAYS        = hss_pkg::WAYS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_func,
   input  logic signed [hss_pkg::KEY_W-1:0]    req_key,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [hss_pkg::STATUS_W-1:0]        rsp_status
);
   import hss_pkg::*;

   localparam int BW = $clog2(NUM_BUCKETS);

   localparam logic [1:0] S_INIT = 2'd0;
   localparam logic [1:0] S_IDLE = 2'd1;
   localparam logic [1:0] S_HASH = 2'd2;
   localparam logic [1:0] S_CMP  = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic                func_ff;
   logic [KEY_W-1:0]    key_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff;

   logic                req_beat, commit;
   logic                hash_done, init_done;
   logic [BW-1:0]       bucket;
   logic [STATUS_W-1:0] status;
   hss_op_type          op;

   assign req_ready = (state_ff == S_IDLE);
   assign req_beat  = req_valid && req_ready;
   // finish the item once the response slot is free
   assign commit    = (state_ff == S_CMP) && (!rsp_valid_ff || rsp_ready);

   hss_hash #(
      .NUM_BUCKETS (NUM_BUCKETS)
   ) u_hash (
      .clock  (clock),
      .reset  (reset),
      .start  (req_beat),
      .key    ($unsigned(req_key)),
      .done   (hash_done),
      .bucket (bucket)
   );

   assign op.commit = commit;
   assign op.func   = func_ff;
   assign op.key    = key_ff;

   hss_table #(
      .NUM_BUCKETS (NUM_BUCKETS),
      .WAYS        (WAYS)
   ) u_table (
      .clock     (clock),
      .reset     (reset),
      .bucket    (bucket),
      .op        (op),
      .init_done (init_done),
      .status    (status)
   );

   // sequence one request at a time
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_INIT: begin
            if (init_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_beat) state_in = S_HASH;
         end
         S_HASH: begin
            if (hash_done) state_in = S_CMP;
         end
         S_CMP: begin
            if (commit) state_in = S_IDLE;
         end
         default: state_in = S_INIT;
      endcase
   end

   // load or drop the response beat
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold request and response payload
   always_ff @(posedge clock) begin
      if (req_beat) begin
         func_ff <= req_func;
         key_ff  <= $unsigned(req_key);
      end
      if (commit) begin
         rsp_status_ff <= status;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;

endmodule

@@ rtl/hss_checker.sv @@
// Port-level checker for the hash set, bound to the top level.
`include "hash_set_insert_search_top_assert.svh"

module hss_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [hss_pkg::STATUS_W-1:0]     rsp_status
);
   import hss_pkg::*;

   // stalled response beat holds its code
   `HSS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status))

   // only defined result codes leave the block
   `HSS_ASSERT_NOW(a_rsp_code, clock, reset, rsp_valid, rsp_status <= ST_FULL)

   // one request in flight: no new beat right after an accept
   `HSS_ASSERT_NEXT(a_one_flight, clock, reset, req_valid && req_ready, !req_ready)

   // a new response appears only while a request is being worked on
   `HSS_ASSERT_NOW(a_rsp_source, clock, reset, $rose(rsp_valid), $past(!req_ready))

endmodule

bind hash_set_insert_search_top hss_checker u_hss_checker (.*);

@@ tb/tb_hash_set_insert_search_top.sv @@
// Self-checking testbench for the hash set: directed table, hot-bucket random beats, predictor.
module tb_hash_set_insert_search_top;
   timeunit 1ns;
   timeprecision 1ps;

   import hss_pkg::*;

   localparam int NB             = NUM_BUCKETS_DEF;
   localparam int NWAYS          = WAYS_DEF;
   localparam int DIR_ROWS       = 24;
   localparam int RANDOM_PER_PH  = 175;
   localparam int DRAIN_CYCLES   = 12;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam logic [31:0] KEY_MIN = 32'h8000_0000;
   localparam logic [31:0] KEY_MAX = 32'h7FFF_FFFF;

   // one row of the directed table; fixed rows carry their status inline
   typedef struct {
      logic                    func;
      logic signed [KEY_W-1:0] key;
      bit                      fixed;
      logic [STATUS_W-1:0]     status;
   } dir_row_type;

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_valid  = 1'b0;
   logic                    req_func   = FUNC_INSERT;
   logic signed [KEY_W-1:0] req_key    = '0;
   logic                    rsp_ready  = 1'b0;
   logic                    req_ready;
   logic                    rsp_valid;
   logic [STATUS_W-1:0]     rsp_status;

   // shadow of the table: key per way, fill count per bucket
   logic [KEY_W-1:0]        shadow_keys [NB][NWAYS];
   int                      shadow_fill [NB] = '{default: 0};
   logic [STATUS_W-1:0]     status_due [$];
   logic signed [KEY_W-1:0] inserted_keys [$];

   int mismatches     = 0;
   int send_idle_pct  = 0;
   int rsp_stall_pct  = 0;
   int quiet_cycles   = 0;

   dir_row_type dir_rows [DIR_ROWS] = '{
      '{FUNC_SEARCH, 32'sd0,          1'b1, ST_ABSENT},
      '{FUNC_INSERT, 32'sd0,          1'b1, ST_INSERTED},
      '{FUNC_INSERT, 32'sd0,          1'b1, ST_DUPLICATE},
      '{FUNC_SEARCH, 32'sd0,          1'b1, ST_PRESENT},
      '{FUNC_INSERT, 32'sd1024,       1'b1, ST_INSERTED},
      '{FUNC_INSERT, -32'sd1024,      1'b1, ST_INSERTED},
      '{FUNC_INSERT, KEY_MIN,         1'b1, ST_INSERTED},
      '{FUNC_INSERT, 32'sd2048,       1'b1, ST_FULL},
      '{FUNC_INSERT, KEY_MIN,         1'b1, ST_DUPLICATE},
      '{FUNC_SEARCH, 32'sd2048,       1'b1, ST_ABSENT},
      '{FUNC_SEARCH, -32'sd1024,      1'b1, ST_PRESENT},
      '{FUNC_SEARCH, KEY_MIN,         1'b1, ST_PRESENT},
      '{FUNC_INSERT, KEY_MAX,         1'b1, ST_INSERTED},
      '{FUNC_INSERT, -32'sd1,         1'b0, ST_INSERTED},
      '{FUNC_SEARCH, -32'sd1,         1'b0, ST_INSERTED},
      '{FUNC_SEARCH, -32'sd2,         1'b0, ST_INSERTED},
      '{FUNC_INSERT, 32'sd1023,       1'b0, ST_INSERTED},
      '{FUNC_INSERT, -32'sd1025,      1'b0, ST_INSERTED},
      '{FUNC_INSERT, 32'sd2047,       1'b0, ST_INSERTED},
      '{FUNC_SEARCH, KEY_MAX,         1'b0, ST_INSERTED},
      '{FUNC_INSERT, 32'h5555_5555,   1'b0, ST_INSERTED},
      '{FUNC_SEARCH, 32'hAAAA_AAAA,   1'b0, ST_INSERTED},
      '{FUNC_INSERT, 32'hAAAA_AAAA,   1'b0, ST_INSERTED},
      '{FUNC_SEARCH, 32'hAAAA_AAAA,   1'b0, ST_INSERTED}
   };

   hash_set_insert_search_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_func   (req_func),
      .req_key    (req_key),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_status (rsp_status)
   );

   always #6 clock = ~clock;

   // non-negative remainder; % truncates toward zero on signed operands
   function automatic int bucket_index(logic signed [KEY_W-1:0] k);
      int r;
      r = k % NB;
      if (r < 0) begin
         r += NB;
      end
      return r;
   endfunction

   // apply one operation to the shadow table and return its status
   function automatic logic [STATUS_W-1:0] hash_set_apply(logic f, logic signed [KEY_W-1:0] k);
      int b;
      bit hit;
      b = bucket_index(k);
      hit = 1'b0;
      for (int w = 0; w < shadow_fill[b]; w++) begin
         if (shadow_keys[b][w] == k) begin
            hit = 1'b1;
         end
      end
      if (f == FUNC_SEARCH) begin
         return hit ? ST_PRESENT : ST_ABSENT;
      end
      if (hit) begin
         return ST_DUPLICATE;
      end
      if (shadow_fill[b] >= NWAYS) begin
         return ST_FULL;
      end
      shadow_keys[b][shadow_fill[b]] = k;
      shadow_fill[b]++;
      return ST_INSERTED;
   endfunction

   // most often keys crowded into a few hot buckets, then reuse, then anything
   function automatic logic signed [KEY_W-1:0] pick_key();
      int sel;
      int hot;
      int lap;
      sel = $urandom_range(99);
      if (sel < 45) begin
         hot = $urandom_range(11) * 93;
         lap = int'($urandom_range(15)) - 8;
         return hot + NB * lap;
      end
      if (sel < 75 && inserted_keys.size() > 0) begin
         return inserted_keys[$urandom_range(inserted_keys.size() - 1)];
      end
      return $urandom;
   endfunction

   task automatic report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
   endtask

   // hold one request beat until accepted, then record its expected status
   task automatic send_beat(logic f, logic signed [KEY_W-1:0] k, bit fixed,
                            logic [STATUS_W-1:0] fixed_status);
      logic [STATUS_W-1:0] predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func  <= f;
      req_key   <= k;
      do @(posedge clock); while (!(req_valid && req_ready));
      predicted = hash_set_apply(f, k);
      status_due.push_back(fixed ? fixed_status : predicted);
      if (f == FUNC_INSERT) begin
         inserted_keys.push_back(k);
      end
   endtask

   // check each response beat against the oldest pending status, then pick next ready
   always @(posedge clock) begin : rsp_side
      logic [STATUS_W-1:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (status_due.size() == 0) begin
            report_mismatch($sformatf("response beat status %0d with nothing pending",
                                      rsp_status));
         end else begin
            want = status_due.pop_front();
            if (rsp_status !== want) begin
               report_mismatch($sformatf("status got %0d want %0d", rsp_status, want));
            end
         end
      end
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // end the run when no beat moves on either channel for too long
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      logic f;
      logic signed [KEY_W-1:0] k;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed table, no idling
      for (int i = 0; i < DIR_ROWS; i++) begin
         send_beat(dir_rows[i].func, dir_rows[i].key, dir_rows[i].fixed,
                   dir_rows[i].status);
      end

      // random beats over four idling phases
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 74; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 74; end
            default: begin send_idle_pct = 27; rsp_stall_pct = 27; end
         endcase
         for (int n = 0; n < RANDOM_PER_PH; n++) begin
            f = ($urandom_range(99) < 55) ? FUNC_INSERT : FUNC_SEARCH;
            k = pick_key();
            send_beat(f, k, 1'b0, ST_INSERTED);
         end
      end
      req_valid <= 1'b0;

      // drain pending responses, then watch for strays
      while (status_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
